// ----- rtl/asd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants of the step detector
// Request payload types, configuration register indexes and the constants
// of the moving-average filter.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int MAG_W      = 16;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int AVG_LENGTH = 5;
  localparam int SUM_W      = MAG_W + $clog2(AVG_LENGTH);
  localparam int POS_W      = (AVG_LENGTH > 1) ? $clog2(AVG_LENGTH) : 1;

  // floor(sum / AVG_LENGTH) as (sum * RECIP_C) >> DIV_SHIFT, exact for any sum
  localparam int DIV_SHIFT  = SUM_W + $clog2(AVG_LENGTH) + 1;
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'(((64'd1 << DIV_SHIFT) + AVG_LENGTH - 1) / AVG_LENGTH);

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS    = 2'd1;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd9356;
  localparam logic [CFG_W-1:0] COOLDOWN_RESET  = 16'd300;

  typedef struct packed {
    logic signed [15:0]  accel_x;
    logic signed [15:0]  accel_y;
    logic signed [15:0]  accel_z;
    logic [TIME_W-1:0]   time_ms;
  } asd_in_t;

  typedef struct packed {
    logic [MAG_W-1:0]  filtered_magnitude;
    logic              step_detected;
    logic [STEP_W-1:0] step_total;
  } asd_out_t;

endpackage : asd_pkg
`default_nettype wire

// ----- rtl/asd_mag.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asd_mag: bit-serial magnitude of a three-axis sample
// Sums the three squares one multiplier bit per cycle, then takes the floor
// square root one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module asd_mag
  import asd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  output logic                    done,
  output logic [MAG_W-1:0]        magnitude
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_SQUARE,
    P_ROOT
  } phase_t;

  localparam int CNT_W = $clog2(MAG_W);
  localparam int ACC_W = 2 * MAG_W;
  localparam int REM_W = MAG_W + 2;

  phase_t             phase;
  logic [CNT_W-1:0]   count;
  logic [MAG_W-1:0]   mcand_x, mcand_y, mcand_z;
  logic [MAG_W-1:0]   mplr_x, mplr_y, mplr_z;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [ACC_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_shift;
  logic [REM_W-1:0]   trial;
  logic [REM_W-1:0]   rem_next;
  logic [MAG_W-1:0]   root_next;

  function automatic logic [MAG_W-1:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  always_comb begin
    acc_next = {acc[ACC_W-2:0], 1'b0}
             + (mplr_x[MAG_W-1] ? ACC_W'(mcand_x) : '0)
             + (mplr_y[MAG_W-1] ? ACC_W'(mcand_y) : '0)
             + (mplr_z[MAG_W-1] ? ACC_W'(mcand_z) : '0);
  end

  // restoring square root step: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_shift = {rem[REM_W-3:0], rad[ACC_W-1 -: 2]};
    trial     = {magnitude, 2'b01};
    if (rem_shift >= trial) begin
      rem_next  = rem_shift - trial;
      root_next = {magnitude[MAG_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_shift;
      root_next = {magnitude[MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            mcand_x <= abs16(accel_x);
            mcand_y <= abs16(accel_y);
            mcand_z <= abs16(accel_z);
            mplr_x  <= abs16(accel_x);
            mplr_y  <= abs16(accel_y);
            mplr_z  <= abs16(accel_z);
            acc     <= '0;
            count   <= CNT_W'(MAG_W - 1);
            phase   <= P_SQUARE;
          end
        end
        P_SQUARE: begin
          acc    <= acc_next;
          mplr_x <= {mplr_x[MAG_W-2:0], 1'b0};
          mplr_y <= {mplr_y[MAG_W-2:0], 1'b0};
          mplr_z <= {mplr_z[MAG_W-2:0], 1'b0};
          count  <= count - 1'b1;
          if (count == '0) begin
            rad       <= acc_next;
            rem       <= '0;
            magnitude <= '0;
            count     <= CNT_W'(MAG_W - 1);
            phase     <= P_ROOT;
          end
        end
        P_ROOT: begin
          rad       <= {rad[ACC_W-3:0], 2'b00};
          rem       <= rem_next;
          magnitude <= root_next;
          count     <= count - 1'b1;
          if (count == '0) begin
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule : asd_mag
`default_nettype wire

// ----- rtl/accel_step_detector_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// accel_step_detector_core: step detector for three-axis accelerometer data
// Input request (in_valid/in_stall/in_data): one sample, x/y/z in raw counts
// and a millisecond timestamp. Output request (out_valid/out_stall/out_data):
// one result per sample with the moving-average magnitude, a step flag and
// the saturating step count.
// A sample passes from acceptance to a valid result through the bit-serial
// sum of squares, the bit-serial square root, the hand-over of the root,
// then the ring update, the scaling multiply and the step decision.
// The input reopens the cycle after the decision, so a new sample is taken
// only once the last is through. The result sits in an output register, so
// the next sample is accepted while a result waits; a stalled receiver
// holds the result and, once a second result is ready, holds the block in
// its decision cycle until the register frees.
// Registers (cfg_we/cfg_index/cfg_data): index 0 step threshold, index 1
// cooldown in ms; other indexes are ignored. Write only while idle.
// Reset (rst, synchronous) clears the magnitude ring, sum, step count and
// last step time and restores threshold 9356 and cooldown 300.
// ----------------------------------------------------------------------------
module accel_step_detector_core
  import asd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire asd_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output asd_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_RING,
    S_SCALE,
    S_DECIDE
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    step_threshold;
  logic [CFG_W-1:0]    cooldown_ms;
  logic [MAG_W-1:0]    magnitude_ring [AVG_LENGTH];
  logic [POS_W-1:0]    ring_position;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [STEP_W-1:0]   step_counter;
  logic [TIME_W-1:0]   last_step_time;
  logic [TIME_W-1:0]   sample_time;
  logic [PROD_W-1:0]   scaled;
  logic [MAG_W-1:0]    filtered;
  logic [TIME_W-1:0]   elapsed;
  logic                step_hit;
  logic                out_free;
  logic                accept;
  logic                mag_done;
  logic [MAG_W-1:0]    mag;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  asd_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .accel_x   (in_data.accel_x),
    .accel_y   (in_data.accel_y),
    .accel_z   (in_data.accel_z),
    .done      (mag_done),
    .magnitude (mag)
  );

  always_comb begin
    running_sum_next = running_sum - SUM_W'(magnitude_ring[ring_position]) + SUM_W'(mag);
    filtered         = scaled[DIV_SHIFT +: MAG_W];
    elapsed          = sample_time - last_step_time;
    step_hit         = (filtered > step_threshold) && (elapsed > TIME_W'(cooldown_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold <= THRESHOLD_RESET;
      cooldown_ms    <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_THRESHOLD: step_threshold <= cfg_data;
        CFG_COOLDOWN_MS:    cooldown_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      ring_position  <= '0;
      running_sum    <= '0;
      step_counter   <= '0;
      last_step_time <= '0;
      for (int i = 0; i < AVG_LENGTH; i++) begin
        magnitude_ring[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sample_time <= in_data.time_ms;
            state       <= S_MAG;
          end
        end
        S_MAG: begin
          if (mag_done) begin
            state <= S_RING;
          end
        end
        S_RING: begin
          magnitude_ring[ring_position] <= mag;
          running_sum                   <= running_sum_next;
          if (ring_position == POS_W'(AVG_LENGTH - 1)) begin
            ring_position <= '0;
          end else begin
            ring_position <= ring_position + 1'b1;
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          scaled <= PROD_W'(running_sum) * PROD_W'(RECIP_C);
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          // hold until the output register can take the result
          if (out_free) begin
            out_valid                   <= 1'b1;
            out_data.filtered_magnitude <= filtered;
            out_data.step_detected      <= step_hit;
            if (step_hit) begin
              last_step_time <= sample_time;
              if (step_counter != STEP_MAX) begin
                step_counter          <= step_counter + 1'b1;
                out_data.step_total   <= step_counter + 1'b1;
              end else begin
                out_data.step_total   <= step_counter;
              end
            end else begin
              out_data.step_total <= step_counter;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : accel_step_detector_core
`default_nettype wire
